// ----- rtl/triangle_plane_slicer_top_defines.svh -----
// ----------------------------------------------------------------------------
// triangle plane slicer assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_SLICER_TOP_DEFINES_SVH
`define TRIANGLE_PLANE_SLICER_TOP_DEFINES_SVH

// same-cycle implication
`define TPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slicer assertion failed");

// next-cycle implication
`define TPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slicer assertion failed");

`endif

// ----- rtl/tps_pkg.sv -----
// ----------------------------------------------------------------------------
// tps_pkg
// shared widths and constants of the triangle plane slicer
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int MAG_W       = COORD_W;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int THR_W       = 31;
  localparam int STEP_W      = $clog2(PROD_W);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic        [PROD_W-1:0]  prod_t;

endpackage

// ----- rtl/triangle_plane_slicer_top.sv -----
// ----------------------------------------------------------------------------
// triangle_plane_slicer_top
// cuts one triangle per word with the layer plane, emits zero or one segment
// each cut point is either interpolated by the divider pair or taken from a vertex,
// and a vv cut first scans the stored segments for a match before it emits
// one triangle at a time; the divider and the store read port set the rate
// synchronous active-low reset clears control, count, layer_z 0, threshold 66
// segment store contents are not cleared
// ----------------------------------------------------------------------------
`include "triangle_plane_slicer_top_defines.svh"

module triangle_plane_slicer_top
  import tps_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz
  input  logic [287:0] in_tdata,
  // new_layer
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // seg_x1, seg_y1, seg_x2, seg_y2
  output logic [127:0] out_tdata,
  // seg_kind, store_overflow
  output logic [2:0]   out_tuser,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_idx,
  input  logic [31:0]  cfg_wdata
);

  localparam logic [0:0] REG_LAYER_Z   = 1'b0;
  localparam logic [0:0] REG_THRESHOLD = 1'b1;

  localparam logic [1:0] KIND_EE = 2'd0;
  localparam logic [1:0] KIND_EV = 2'd1;
  localparam logic [1:0] KIND_VV = 2'd2;

  typedef enum logic [2:0] {
    SRC_AB, SRC_AC, SRC_BC, SRC_A, SRC_B, SRC_C
  } src_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLASS = 7'b0000010,
    ST_PREP  = 7'b0000100,
    ST_DIVS  = 7'b0001000,
    ST_DIVW  = 7'b0010000,
    ST_SCAN  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  localparam int SUM_W = COORD_W + 4;
  localparam logic [PROD_W-1:0] OFF_LIM = PROD_W'(1) << (COORD_W + 1);
  localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'((64'd1 << (COORD_W - 1)) - 64'd1);
  localparam logic signed [SUM_W-1:0] C_MIN = -C_MAX - SUM_W'(1);

  state_t state_r;
  coord_t layer_z_r;
  logic [THR_W-1:0] thr_r;
  coord_t ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r, cz_r;
  logic [CNT_W-1:0] store_cnt_r;
  logic [1:0] kind_r;
  src_t src1_r, src2_r;
  logic pt_sel_r;
  coord_t p1x_r, p1y_r, p2x_r, p2y_r;
  coord_t px_r, py_r;
  logic neg_x_r, neg_y_r;
  prod_t prod_x_r, prod_y_r;
  mag_t den_r;
  logic [CNT_W-1:0] scan_idx_r;
  logic rd_vld_r;
  logic [4*COORD_W-1:0] rd_data_r;
  logic [4*COORD_W-1:0] mem [STORE_DEPTH];
  logic out_tvalid_r;
  logic [127:0] out_data_r;
  logic [2:0] out_user_r;

  // classification
  logic signed [DIFF_W+1:0] lz_e, th_e, az_e, bz_e, cz_e;
  logic cr_ab, cr_ac, cr_bc, on_a, on_b, on_c;
  logic cls_hit;
  logic [1:0] cls_kind;
  src_t cls_src1, cls_src2;

  function automatic logic is_cross(input logic signed [DIFF_W+1:0] pz,
                                    input logic signed [DIFF_W+1:0] qz,
                                    input logic signed [DIFF_W+1:0] lz,
                                    input logic signed [DIFF_W+1:0] th);
    return ((pz + th < lz) && (lz < qz - th)) || ((qz + th < lz) && (lz < pz - th));
  endfunction

  function automatic logic is_on(input logic signed [DIFF_W+1:0] vz,
                                 input logic signed [DIFF_W+1:0] lz,
                                 input logic signed [DIFF_W+1:0] th);
    logic signed [DIFF_W+1:0] d;
    d = lz - vz;
    if (d < 0) d = -d;
    return d < th;
  endfunction

  function automatic mag_t mag33(input diff_t v);
    diff_t m;
    m = v[DIFF_W-1] ? -v : v;
    return m[MAG_W-1:0];
  endfunction

  function automatic logic near(input coord_t ux, input coord_t uy,
                                input coord_t vx, input coord_t vy,
                                input logic [THR_W-1:0] th);
    diff_t dx, dy;
    dx = DIFF_W'(ux) - DIFF_W'(vx);
    dy = DIFF_W'(uy) - DIFF_W'(vy);
    return (mag33(dx) < MAG_W'(th)) && (mag33(dy) < MAG_W'(th));
  endfunction

  always_comb begin
    lz_e = (DIFF_W+2)'(layer_z_r);
    th_e = (DIFF_W+2)'({1'b0, thr_r});
    az_e = (DIFF_W+2)'(az_r);
    bz_e = (DIFF_W+2)'(bz_r);
    cz_e = (DIFF_W+2)'(cz_r);
    cr_ab = is_cross(az_e, bz_e, lz_e, th_e);
    cr_ac = is_cross(az_e, cz_e, lz_e, th_e);
    cr_bc = is_cross(bz_e, cz_e, lz_e, th_e);
    on_a = is_on(az_e, lz_e, th_e);
    on_b = is_on(bz_e, lz_e, th_e);
    on_c = is_on(cz_e, lz_e, th_e);
    cls_hit  = 1'b1;
    cls_kind = KIND_EE;
    cls_src1 = SRC_AB;
    cls_src2 = SRC_BC;
    if (cr_ab) begin
      cls_src1 = SRC_AB;
      if (cr_ac) cls_src2 = SRC_AC;
      else if (on_c) begin
        cls_src2 = SRC_C;
        cls_kind = KIND_EV;
      end
    end else if (cr_ac) begin
      cls_src1 = SRC_AC;
      if (on_b) begin
        cls_src2 = SRC_B;
        cls_kind = KIND_EV;
      end
    end else if (on_a) begin
      cls_src1 = SRC_A;
      if (cr_bc) cls_kind = KIND_EV;
      else if (on_b) begin
        cls_src2 = SRC_B;
        cls_kind = KIND_VV;
        cls_hit  = !on_c;
      end else if (on_c) begin
        cls_src2 = SRC_C;
        cls_kind = KIND_VV;
      end else cls_hit = 1'b0;
    end else if (on_b && on_c) begin
      cls_src1 = SRC_B;
      cls_src2 = SRC_C;
      cls_kind = KIND_VV;
    end else cls_hit = 1'b0;
  end

  // point source selection
  src_t cur_src;
  coord_t sp_x, sp_y, sp_z, sq_x, sq_y, sq_z;
  logic cur_is_edge;
  diff_t t_d, dz_d, dx_d, dy_d;

  always_comb begin
    cur_src = pt_sel_r ? src2_r : src1_r;
    cur_is_edge = 1'b1;
    sp_x = ax_r; sp_y = ay_r; sp_z = az_r;
    sq_x = bx_r; sq_y = by_r; sq_z = bz_r;
    case (cur_src)
      SRC_AB: begin
        sq_x = bx_r; sq_y = by_r; sq_z = bz_r;
      end
      SRC_AC: begin
        sq_x = cx_r; sq_y = cy_r; sq_z = cz_r;
      end
      SRC_BC: begin
        sp_x = bx_r; sp_y = by_r; sp_z = bz_r;
        sq_x = cx_r; sq_y = cy_r; sq_z = cz_r;
      end
      SRC_A: cur_is_edge = 1'b0;
      SRC_B: begin
        cur_is_edge = 1'b0;
        sp_x = bx_r; sp_y = by_r; sp_z = bz_r;
      end
      SRC_C: begin
        cur_is_edge = 1'b0;
        sp_x = cx_r; sp_y = cy_r; sp_z = cz_r;
      end
      default: cur_is_edge = 1'b0;
    endcase
    t_d  = DIFF_W'(layer_z_r) - DIFF_W'(sp_z);
    dz_d = DIFF_W'(sq_z) - DIFF_W'(sp_z);
    dx_d = DIFF_W'(sq_x) - DIFF_W'(sp_x);
    dy_d = DIFF_W'(sq_y) - DIFF_W'(sp_y);
  end

  // divider pair
  logic div_start;
  logic div_done_x, div_done_y;
  prod_t quo_x, quo_y;

  assign div_start = (state_r == ST_DIVS);

  tps_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_x_r),
    .divisor  (den_r),
    .done     (div_done_x),
    .quotient (quo_x)
  );

  tps_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_y_r),
    .divisor  (den_r),
    .done     (div_done_y),
    .quotient (quo_y)
  );

  function automatic coord_t finish(input coord_t p, input prod_t q, input logic neg);
    logic [PROD_W-1:0] off;
    logic signed [SUM_W-1:0] s;
    off = (q > OFF_LIM) ? OFF_LIM : q;
    s = neg ? (SUM_W'(p) - SUM_W'(off[COORD_W+1:0]))
            : (SUM_W'(p) + SUM_W'(off[COORD_W+1:0]));
    if (s > C_MAX) s = C_MAX;
    else if (s < C_MIN) s = C_MIN;
    return s[COORD_W-1:0];
  endfunction

  coord_t fin_x, fin_y;
  assign fin_x = finish(px_r, quo_x, neg_x_r);
  assign fin_y = finish(py_r, quo_y, neg_y_r);

  // scan and emit control
  logic scan_issue, scan_match, emit_go, mem_we;
  coord_t r_x1, r_y1, r_x2, r_y2;

  assign scan_issue = (state_r == ST_SCAN) && (scan_idx_r < store_cnt_r);
  assign r_x1 = rd_data_r[COORD_W-1:0];
  assign r_y1 = rd_data_r[2*COORD_W-1:COORD_W];
  assign r_x2 = rd_data_r[3*COORD_W-1:2*COORD_W];
  assign r_y2 = rd_data_r[4*COORD_W-1:3*COORD_W];
  assign scan_match = rd_vld_r &&
    ((near(p1x_r, p1y_r, r_x1, r_y1, thr_r) && near(p2x_r, p2y_r, r_x2, r_y2, thr_r)) ||
     (near(p1x_r, p1y_r, r_x2, r_y2, thr_r) && near(p2x_r, p2y_r, r_x1, r_y1, thr_r)));
  assign emit_go = (state_r == ST_EMIT) && (!out_tvalid_r || out_tready);
  assign mem_we  = emit_go && (store_cnt_r < CNT_W'(STORE_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) mem[store_cnt_r[ADDR_W-1:0]] <= {p2y_r, p2x_r, p1y_r, p1x_r};
    rd_data_r <= mem[scan_idx_r[ADDR_W-1:0]];
  end

  // point done: store and move on
  logic pt_done;
  coord_t pt_x, pt_y;
  state_t after_pts;

  always_comb begin
    pt_done = 1'b0;
    pt_x = sp_x;
    pt_y = sp_y;
    if (state_r == ST_PREP) pt_done = !cur_is_edge || (dz_d == '0);
    else if (state_r == ST_DIVW && div_done_x) begin
      pt_done = 1'b1;
      pt_x = fin_x;
      pt_y = fin_y;
    end
    after_pts = ((kind_r == KIND_VV) && (store_cnt_r != '0)) ? ST_SCAN : ST_EMIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      layer_z_r    <= '0;
      thr_r        <= THR_W'(66);
      store_cnt_r  <= '0;
      out_tvalid_r <= 1'b0;
      pt_sel_r     <= 1'b0;
      rd_vld_r     <= 1'b0;
      scan_idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_LAYER_Z:   layer_z_r <= cfg_wdata;
          REG_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (emit_go) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
      rd_vld_r <= scan_issue;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            if (in_tuser[0]) store_cnt_r <= '0;
            state_r <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          pt_sel_r <= 1'b0;
          state_r  <= cls_hit ? ST_PREP : ST_IDLE;
        end
        ST_PREP: begin
          if (!pt_done) state_r <= ST_DIVS;
        end
        ST_DIVS: state_r <= ST_DIVW;
        ST_DIVW: ;
        ST_SCAN: begin
          if (scan_issue) scan_idx_r <= scan_idx_r + 1'b1;
          if (scan_match) state_r <= ST_IDLE;
          else if (!scan_issue && !rd_vld_r) state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (mem_we) store_cnt_r <= store_cnt_r + 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (pt_done) begin
        pt_sel_r <= 1'b1;
        if (pt_sel_r) begin
          state_r    <= after_pts;
          scan_idx_r <= '0;
        end else begin
          state_r <= ST_PREP;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      ax_r <= in_tdata[31:0];
      ay_r <= in_tdata[63:32];
      az_r <= in_tdata[95:64];
      bx_r <= in_tdata[127:96];
      by_r <= in_tdata[159:128];
      bz_r <= in_tdata[191:160];
      cx_r <= in_tdata[223:192];
      cy_r <= in_tdata[255:224];
      cz_r <= in_tdata[287:256];
    end
    if (state_r == ST_CLASS) begin
      kind_r <= cls_kind;
      src1_r <= cls_src1;
      src2_r <= cls_src2;
    end
    if (state_r == ST_PREP) begin
      px_r     <= sp_x;
      py_r     <= sp_y;
      prod_x_r <= mag33(t_d) * mag33(dx_d);
      prod_y_r <= mag33(t_d) * mag33(dy_d);
      neg_x_r  <= t_d[DIFF_W-1] ^ dx_d[DIFF_W-1] ^ dz_d[DIFF_W-1];
      neg_y_r  <= t_d[DIFF_W-1] ^ dy_d[DIFF_W-1] ^ dz_d[DIFF_W-1];
      den_r    <= mag33(dz_d);
    end
    if (pt_done) begin
      if (pt_sel_r) begin
        p2x_r <= pt_x;
        p2y_r <= pt_y;
      end else begin
        p1x_r <= pt_x;
        p1y_r <= pt_y;
      end
    end
    if (emit_go) begin
      out_data_r <= {p2y_r, p2x_r, p1y_r, p1x_r};
      out_user_r <= {!mem_we, kind_r};
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `TPS_ASSERT_NOW(a_cnt_bound, 1'b1, store_cnt_r <= CNT_W'(STORE_DEPTH))
  `TPS_ASSERT_NOW(a_we_room, mem_we, store_cnt_r < CNT_W'(STORE_DEPTH))
  `TPS_ASSERT_NEXT(a_out_from_emit, (state_r != ST_EMIT) && !out_tvalid_r, !out_tvalid_r)
  `TPS_ASSERT_NOW(a_div_pair, div_done_x || div_done_y, div_done_x && div_done_y)

endmodule

// ----- rtl/tps_div.sv -----
// ----------------------------------------------------------------------------
// tps_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tps_div
  import tps_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  prod_t dividend,
  input  mag_t  divisor,
  output logic  done,
  output prod_t quotient
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  mag_t              rem_r;
  prod_t             quo_r;
  logic [MAG_W:0]    shifted;
  logic [MAG_W:0]    trial;

  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign trial   = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      if (!trial[MAG_W]) begin
        rem_r <= trial[MAG_W-1:0];
        quo_r <= {quo_r[PROD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[MAG_W-1:0];
        quo_r <= {quo_r[PROD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
